>>> design/chrl_pkg.sv
// Package for the consistent hash ring lookup block.
// Holds the item structs, opcode and sequencer codes, FNV-1a constants.
// No dependencies.
`default_nettype none

package chrl_pkg;

  localparam int unsigned RingEntriesDef = 256;
  // Highest node index plus one that an insert may carry
  localparam int unsigned NodeCount      = 256;

  localparam int unsigned TokenW = 64;
  localparam int unsigned NodeW  = 8;

  localparam logic [TokenW-1:0] FnvBasis = 64'hcbf29ce484222325;
  // FNV prime is 2^40 + 0x1B3
  localparam int unsigned       FnvPrimeShift = 40;
  localparam logic [8:0]        FnvPrimeLo    = 9'h1B3;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_BYTE   = 2'd2,
    OP_LOOKUP = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_LOOK_RD,
    ST_LOOK_CMP,
    ST_WRAP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [TokenW-1:0] entry_token;
    logic [NodeW-1:0]  entry_node;
    logic [7:0]        name_byte;
    logic              name_last;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [NodeW-1:0]  owner_node;
    logic [TokenW-1:0] name_hash;
    logic              ring_overflowed;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/chrl_fnv_step.sv
// One FNV-1a 64-bit step: xor a byte into the hash, multiply by the prime.
// Uses chrl_pkg for widths and the prime split into shift and small factor.
`default_nettype none

module chrl_fnv_step
  import chrl_pkg::*;
(
  input  wire logic [TokenW-1:0] hash_i,
  input  wire logic [7:0]        byte_i,
  output logic      [TokenW-1:0] hash_o
);

  logic [TokenW-1:0] mixed;
  logic [TokenW-1:0] prod_lo;

  assign mixed   = hash_i ^ {{(TokenW-8){1'b0}}, byte_i};
  // 64 x 9 bit constant product, plus the 2^40 term as a shift
  assign prod_lo = mixed * {{(TokenW-9){1'b0}}, FnvPrimeLo};
  assign hash_o  = (mixed << FnvPrimeShift) + prod_lo;

endmodule

`default_nettype wire

>>> design/chrl_ring_mem.sv
// Ring storage: token and node per entry, one write and one read port.
// Read data is registered. Uses chrl_pkg for widths.
`default_nettype none

module chrl_ring_mem
  import chrl_pkg::*;
#(
  parameter int unsigned DEPTH = RingEntriesDef,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [TokenW-1:0] wtok_i,
  input  wire logic [NodeW-1:0]  wnode_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [TokenW-1:0] rtok_o,
  output logic      [NodeW-1:0]  rnode_o
);

  logic [TokenW-1:0] tok_mem  [DEPTH];
  logic [NodeW-1:0]  node_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      tok_mem[waddr_i]  <= wtok_i;
      node_mem[waddr_i] <= wnode_i;
    end
    rtok_o  <= tok_mem[raddr_i];
    rnode_o <= node_mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/consistent_hash_ring_lookup.sv
// Consistent hash ring lookup with FNV-1a 64-bit name hashing.
//
// Input channel (in_valid_i / in_stall_o / in_i) takes clear, insert, name
// byte and empty-name lookup items. Output channel (out_valid_o /
// out_stall_i / out_o) gives one result for each last name byte and each
// empty-name lookup. An item moves when valid is high and stall is low.
// Name bytes that are not last only update the name hash. A lookup reads
// and compares one ring entry at a time with the single token comparator,
// wrapping to the lowest entry when no token is at or above the hash; an
// empty ring skips the scan. An insert scans the same way, then moves
// entries up one slot through the single write port and places the token;
// an overwrite or a dropped insert ends after the scan. Clear leaves the sequencer idle.
// in_stall_o is high while the sequencer works on an item.
// Results sit in an output register; while the receiver stalls, the next
// result waits in the sequencer and new items are held off.
// Reset empties the ring, clears the overflow flag and restarts the name
// hash. Ring storage is not cleared; only entries below the count are read.
// Uses chrl_pkg, chrl_fnv_step and chrl_ring_mem.
`default_nettype none

module consistent_hash_ring_lookup
  import chrl_pkg::*;
#(
  parameter int unsigned RING_ENTRIES = RingEntriesDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_o
);

  localparam int unsigned AW = $clog2(RING_ENTRIES);
  localparam int unsigned CW = $clog2(RING_ENTRIES + 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     sh_q, sh_d;
  logic              ovf_q, ovf_d;
  logic [TokenW-1:0] hash_q, hash_d;
  logic [TokenW-1:0] key_q, key_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic              res_found_q, res_found_d;
  logic [NodeW-1:0]  res_node_q, res_node_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              in_acc;
  logic              out_load;
  logic              ring_full;
  logic              node_ok;
  logic [TokenW-1:0] hash_next;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [TokenW-1:0] mem_wtok;
  logic [NodeW-1:0]  mem_wnode;
  logic [AW-1:0]     mem_raddr;
  logic [TokenW-1:0] mem_rtok;
  logic [NodeW-1:0]  mem_rnode;

  // Shared token comparator
  logic              cmp_lt;
  logic              cmp_eq;

  chrl_fnv_step u_fnv (
    .hash_i (hash_q),
    .byte_i (in_i.name_byte),
    .hash_o (hash_next)
  );

  chrl_ring_mem #(
    .DEPTH (RING_ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wtok_i  (mem_wtok),
    .wnode_i (mem_wnode),
    .raddr_i (mem_raddr),
    .rtok_o  (mem_rtok),
    .rnode_o (mem_rnode)
  );

  assign cmp_lt    = mem_rtok < key_q;
  assign cmp_eq    = mem_rtok == key_q;
  assign ring_full = cnt_q == CW'(RING_ENTRIES);
  assign node_ok   = {24'd0, in_i.entry_node} < 32'(NodeCount);

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    sh_d        = sh_q;
    ovf_d       = ovf_q;
    hash_d      = hash_q;
    key_d       = key_q;
    node_d      = node_q;
    res_found_d = res_found_q;
    res_node_d  = res_node_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wtok    = key_q;
    mem_wnode   = node_q;
    mem_raddr   = idx_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.opcode)
            OP_CLEAR: begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
            OP_INSERT: begin
              if (node_ok) begin
                key_d   = in_i.entry_token;
                node_d  = in_i.entry_node;
                idx_d   = '0;
                state_d = ST_FIND_RD;
              end
            end
            OP_BYTE: begin
              if (!in_i.name_last) begin
                hash_d = hash_next;
              end else begin
                hash_d = FnvBasis;
                key_d  = hash_next;
              end
            end
            default: begin
              hash_d = FnvBasis;
              key_d  = FnvBasis;
            end
          endcase
          // Start the ring search for a finished name
          if ((in_i.opcode == OP_LOOKUP) ||
              ((in_i.opcode == OP_BYTE) && in_i.name_last)) begin
            idx_d = '0;
            if (cnt_q == '0) begin
              res_found_d = 1'b0;
              res_node_d  = '0;
              state_d     = ST_EMIT;
            end else begin
              state_d = ST_LOOK_RD;
            end
          end
        end
      end

      ST_FIND_RD: begin
        if (idx_q == cnt_q) begin
          // New token goes at the end, or is dropped when the ring is full
          if (ring_full) begin
            ovf_d   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_PLACE;
          end
        end else begin
          state_d = ST_FIND_CMP;
        end
      end

      ST_FIND_CMP: begin
        if (cmp_eq) begin
          // Overwrite the node of an existing token
          mem_we  = 1'b1;
          state_d = ST_IDLE;
        end else if (cmp_lt) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_FIND_RD;
        end else if (ring_full) begin
          ovf_d   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          sh_d    = cnt_q;
          state_d = ST_SHIFT_RD;
        end
      end

      ST_SHIFT_RD: begin
        mem_raddr = AW'(sh_q - 1'b1);
        if (sh_q == idx_q) begin
          state_d = ST_PLACE;
        end else begin
          state_d = ST_SHIFT_WR;
        end
      end

      ST_SHIFT_WR: begin
        // Move entry one slot up
        mem_we    = 1'b1;
        mem_waddr = sh_q[AW-1:0];
        mem_wtok  = mem_rtok;
        mem_wnode = mem_rnode;
        sh_d      = sh_q - 1'b1;
        state_d   = ST_SHIFT_RD;
      end

      ST_PLACE: begin
        mem_we  = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = ST_IDLE;
      end

      ST_LOOK_RD: begin
        if (idx_q == cnt_q) begin
          // No token at or above the hash: wrap to the lowest
          mem_raddr = '0;
          state_d   = ST_WRAP;
        end else begin
          state_d = ST_LOOK_CMP;
        end
      end

      ST_LOOK_CMP: begin
        if (cmp_lt) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_LOOK_RD;
        end else begin
          res_found_d = 1'b1;
          res_node_d  = mem_rnode;
          state_d     = ST_EMIT;
        end
      end

      ST_WRAP: begin
        res_found_d = 1'b1;
        res_node_d  = mem_rnode;
        state_d     = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d           = 1'b1;
      out_d.found           = res_found_q;
      out_d.owner_node      = res_node_q;
      out_d.name_hash       = key_q;
      out_d.ring_overflowed = ovf_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      hash_q      <= FnvBasis;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    sh_q        <= sh_d;
    key_q       <= key_d;
    node_q      <= node_d;
    res_found_q <= res_found_d;
    res_node_q  <= res_node_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> tb/sv/tb_consistent_hash_ring_lookup.sv
// Self-checking testbench for consistent_hash_ring_lookup.
// Predicts every lookup result from its own sorted ring and FNV-1a hash state.
// Depends on chrl_pkg and the consistent_hash_ring_lookup RTL only.
module tb_consistent_hash_ring_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import chrl_pkg::*;

  localparam int unsigned RingDepth   = RingEntriesDef;
  localparam int unsigned ItemTarget  = 1750;
  localparam int unsigned DrainCycles = 4 * RingDepth + 16;
  localparam int unsigned HoldCycles  = 300;
  localparam logic [63:0] FnvPrime64  = 64'h0000_0100_0000_01B3;

  typedef logic [7:0] name_q_t[$];
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  class owner_lookup_board;
    logic [63:0] tokens[$];
    logic [7:0]  nodes[$];
    logic [63:0] hash_acc;
    bit          overflow;
    int unsigned capacity;
    out_item_t   pending_owners[$];
    int unsigned fails;

    function new(int unsigned depth);
      capacity = depth;
      hash_acc = FnvBasis;
      overflow = 1'b0;
      fails    = 0;
    endfunction

    static function logic [63:0] fnv_fold(logic [63:0] h, logic [7:0] b);
      return (h ^ {56'd0, b}) * FnvPrime64;
    endfunction

    // First slot whose token is not below the key
    function int unsigned slot_for(logic [63:0] key);
      int unsigned i;
      i = 0;
      while (i < tokens.size() && tokens[i] < key) i++;
      return i;
    endfunction

    function void predict_owner(logic [63:0] h);
      out_item_t   e;
      int unsigned pos;
      e.found           = (tokens.size() > 0);
      e.owner_node      = '0;
      e.name_hash       = h;
      e.ring_overflowed = overflow;
      if (e.found) begin
        pos = slot_for(h);
        if (pos >= tokens.size()) pos = 0;
        e.owner_node = nodes[pos];
      end
      pending_owners.push_back(e);
    endfunction

    function void accept_item(in_item_t it);
      int unsigned pos;
      case (it.opcode)
        OP_CLEAR: begin
          tokens.delete();
          nodes.delete();
          overflow = 1'b0;
        end
        OP_INSERT: begin
          if (int'(it.entry_node) < int'(NodeCount)) begin
            pos = slot_for(it.entry_token);
            if (pos < tokens.size() && tokens[pos] == it.entry_token) begin
              nodes[pos] = it.entry_node;
            end else if (tokens.size() >= capacity) begin
              overflow = 1'b1;
            end else begin
              tokens.insert(pos, it.entry_token);
              nodes.insert(pos, it.entry_node);
            end
          end
        end
        OP_BYTE: begin
          hash_acc = fnv_fold(hash_acc, it.name_byte);
          if (it.name_last) begin
            predict_owner(hash_acc);
            hash_acc = FnvBasis;
          end
        end
        default: begin
          hash_acc = FnvBasis;
          predict_owner(FnvBasis);
        end
      endcase
    endfunction

    function void check_owner(out_item_t got);
      out_item_t exp;
      if (pending_owners.size() == 0) begin
        $error("result arrived with no lookup pending: %p", got);
        fails++;
        return;
      end
      exp = pending_owners.pop_front();
      if (got.found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, got.found);
        fails++;
      end
      if (got.owner_node !== exp.owner_node) begin
        $error("owner_node: expected 0x%02h, got 0x%02h", exp.owner_node, got.owner_node);
        fails++;
      end
      if (got.name_hash !== exp.name_hash) begin
        $error("name_hash: expected 0x%016h, got 0x%016h", exp.name_hash, got.name_hash);
        fails++;
      end
      if (got.ring_overflowed !== exp.ring_overflowed) begin
        $error("ring_overflowed: expected %0d, got %0d",
               exp.ring_overflowed, got.ring_overflowed);
        fails++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  owner_lookup_board board;
  bit          want_hold = 1'b0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;

  consistent_hash_ring_lookup #(
    .RING_ENTRIES(RingDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_item_t mk(opcode_e op);
    in_item_t it;
    it.opcode      = op;
    it.entry_token = {$urandom, $urandom};
    it.entry_node  = 8'($urandom);
    it.name_byte   = 8'($urandom);
    it.name_last   = 1'($urandom);
    return it;
  endfunction

  function automatic name_q_t random_name(int unsigned len);
    name_q_t nm;
    for (int unsigned i = 0; i < len; i++) nm.push_back(8'($urandom));
    return nm;
  endfunction

  function automatic logic [63:0] name_digest(name_q_t nm);
    logic [63:0] h;
    h = FnvBasis;
    foreach (nm[i]) h = owner_lookup_board::fnv_fold(h, nm[i]);
    return h;
  endfunction

  // Hold the item until accepted, then maybe pause between bursts
  task automatic offer_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    board.accept_item(it);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic put_op(input opcode_e op);
    offer_item(mk(op));
  endtask

  task automatic put_entry(input logic [63:0] tok, input logic [7:0] node);
    in_item_t it;
    it = mk(OP_INSERT);
    it.entry_token = tok;
    it.entry_node  = node;
    offer_item(it);
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it = mk(OP_BYTE);
    it.name_byte = b;
    it.name_last = last;
    offer_item(it);
  endtask

  task automatic send_name(input name_q_t nm);
    foreach (nm[i]) put_byte(nm[i], i == nm.size() - 1);
  endtask

  task automatic run_directed();
    name_q_t nm;
    put_op(OP_LOOKUP);                         // empty ring
    put_byte(8'h00, 1'b1);
    put_entry(64'h0, 8'hFF);
    put_entry(64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    put_entry(64'h8000_0000_0000_0000, 8'h5A);
    put_op(OP_LOOKUP);                         // offset basis lands on top token
    put_entry(64'hFFFF_FFFF_FFFF_FFFF, 8'hA5); // overwrite
    put_byte(8'hFF, 1'b1);
    // clear in the middle of a name keeps the partial hash; the lookup after it drops it
    nm = '{8'h00, 8'hFF, 8'h7E};
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_op(OP_CLEAR);
    put_op(OP_LOOKUP);
    put_entry(name_digest(nm), 8'h3C);
    put_byte(8'h7E, 1'b1);                     // the lookup above reset the hash, so this hashes 8'h7E alone
    // empty-name lookup drops a partial name
    put_byte(8'h11, 1'b0);
    put_op(OP_LOOKUP);
    nm = '{8'h22};
    put_entry(name_digest(nm) - 64'd1, 8'h11);
    put_entry(name_digest(nm) + 64'd1, 8'h12);
    send_name(nm);
    put_op(OP_CLEAR);
    put_byte(8'h5C, 1'b1);
  endtask

  // Fill the ring to capacity, then push past it
  task automatic run_full_ring();
    int unsigned n;
    put_op(OP_CLEAR);
    n = 0;
    while (board.tokens.size() < RingDepth) begin
      put_entry({$urandom, $urandom}, 8'($urandom));
      if (++n % 64 == 0) send_name(random_name($urandom_range(1, 4)));
    end
    send_name(random_name(2));
    repeat (4) put_entry({$urandom, $urandom}, 8'($urandom));
    put_entry(board.tokens[0], 8'($urandom));
    put_entry(board.tokens[RingDepth - 1], 8'($urandom));
    put_entry(board.tokens[$urandom_range(0, RingDepth - 1)], 8'($urandom));
    put_op(OP_LOOKUP);
    repeat (6) send_name(random_name($urandom_range(1, 5)));
    put_op(OP_CLEAR);
    send_name(random_name(1));
  endtask

  // Results pile up while the receiver holds off
  task automatic run_hold_off();
    want_hold = 1'b1;
    repeat (12) send_name(random_name(1));
  endtask

  task automatic run_session();
    name_q_t     nm;
    logic [63:0] h;
    if ($urandom_range(0, 3) == 0 || board.tokens.size() > 40) put_op(OP_CLEAR);
    repeat ($urandom_range(0, 20)) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          if (board.tokens.size() > 0)
            put_entry(board.tokens[$urandom_range(0, board.tokens.size() - 1)],
                      8'($urandom));
          else
            put_entry(64'h0, 8'($urandom));
        end
        3: put_entry(($urandom_range(0, 1) != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0,
                     8'($urandom));
        default: put_entry({$urandom, $urandom}, 8'($urandom));
      endcase
    end
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 19))
        0, 1, 2: put_op(OP_LOOKUP);
        3, 4, 5: begin
          // place a token right around the hash of the coming name
          nm = random_name($urandom_range(1, 4));
          h  = name_digest(nm);
          case ($urandom_range(0, 2))
            0: put_entry(h - 64'd1, 8'($urandom));
            1: put_entry(h, 8'($urandom));
            default: put_entry(h + 64'd1, 8'($urandom));
          endcase
          send_name(nm);
        end
        6, 7: begin
          // broken name: noise lands between the bytes
          put_byte(8'($urandom), 1'b0);
          offer_item(mk(opcode_e'($urandom_range(0, 3))));
          put_byte(8'($urandom), 1'($urandom));
        end
        default: send_name(random_name($urandom_range(1, 6)));
      endcase
    end
  endtask

  // Receiver: check each accepted result, stall on a pattern of its own
  initial begin
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) board.check_owner(out_data);
      if (want_hold && hold_left == 0) begin
        hold_left = HoldCycles;
        want_hold = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin
    bit full_done;
    bit hold_done;
    board     = new(RingDepth);
    full_done = 1'b0;
    hold_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    while (items_sent < ItemTarget) begin
      if (!hold_done && items_sent > 300) begin
        run_hold_off();
        hold_done = 1'b1;
      end else if (!full_done && items_sent > 600) begin
        run_full_ring();
        full_done = 1'b1;
      end else begin
        run_session();
      end
    end
    in_valid <= 1'b0;
    while (board.pending_owners.size() != 0) @(posedge clk_i);
    // catch any stray result after the last expected one
    repeat (DrainCycles) @(posedge clk_i);
    if (board.fails == 0 && board.pending_owners.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/chrl_pkg.sv
design/chrl_fnv_step.sv
design/chrl_ring_mem.sv
design/consistent_hash_ring_lookup.sv
tb/sv/tb_consistent_hash_ring_lookup.sv
